// File: rtl/tsr_pkg.sv
// Shared types, constants and the control program of the track segment reservation unit.
package tsr_pkg;

   // Default sizes of the tables.
   localparam int SEGMENTS_DEF = 256;
   localparam int MAX_PATH_DEF = 32;
   localparam int TRAINS_DEF   = 16;

   // Widths of the request fields.
   localparam int TRAIN_IN_W = 4;
   localparam int SEG_IN_W   = 8;

   // Decision codes returned with each response.
   typedef enum logic [1:0] {
      STATUS_GRANTED  = 2'd0,
      STATUS_CONFLICT = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   typedef struct packed {
      logic [TRAIN_IN_W-1:0] train;
      logic [SEG_IN_W-1:0]   segment;
      logic                  segment_valid;
      logic                  last;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [TRAIN_IN_W-1:0] train_out;
   } rsp_type;

   // Jump conditions that the datapath reports to the sequencer.
   typedef enum logic [3:0] {
      COND_NONE      = 4'd0,
      COND_GO        = 4'd1,
      COND_OVERFLOW  = 4'd2,
      COND_N_ZERO    = 4'd3,
      COND_H_ZERO    = 4'd4,
      COND_CHK_MORE  = 4'd5,
      COND_CONFLICT  = 4'd6,
      COND_IDX_END_N = 4'd7,
      COND_IDX_END_H = 4'd8,
      COND_SEG_END   = 4'd9
   } cond_type;

   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;

   // Program addresses.
   localparam step_type STEP_CLEAR     = 5'd0;
   localparam step_type STEP_IDLE      = 5'd1;
   localparam step_type STEP_DISPATCH  = 5'd2;
   localparam step_type STEP_CHK_START = 5'd3;
   localparam step_type STEP_CHK_RD    = 5'd4;
   localparam step_type STEP_CHK_OWN   = 5'd5;
   localparam step_type STEP_CHK_CMP   = 5'd6;
   localparam step_type STEP_CHK_END   = 5'd7;
   localparam step_type STEP_REL_START = 5'd8;
   localparam step_type STEP_REL_RD    = 5'd9;
   localparam step_type STEP_REL_WR    = 5'd10;
   localparam step_type STEP_CLM_START = 5'd11;
   localparam step_type STEP_CLM_RD    = 5'd12;
   localparam step_type STEP_CLM_WR    = 5'd13;
   localparam step_type STEP_GRANT     = 5'd14;
   localparam step_type STEP_CONFLICT  = 5'd15;
   localparam step_type STEP_TOO_LONG  = 5'd16;

   // One control word of the program.
   typedef struct packed {
      logic       busy;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_stage;
      logic       rd_held;
      logic       rd_owner;
      logic       wr_clear;
      logic       wr_free;
      logic       wr_claim;
      logic       set_len;
      logic       respond;
      status_type status;
      cond_type   cond;
      logic       jump_on;
      step_type   target;
   } ucode_word_type;

   // Status flags from the datapath.
   typedef struct packed {
      logic go;
      logic overflow;
      logic n_zero;
      logic h_zero;
      logic conflict;
      logic idx_end_n;
      logic idx_end_h;
      logic seg_end;
   } flags_type;

   // Control store. A word jumps to its target when its condition equals jump_on,
   // otherwise it falls through to the next address. COND_NONE is always false, so
   // jump_on low on COND_NONE makes an unconditional jump.
   function automatic ucode_word_type ucode_fetch(input step_type step);
      ucode_word_type w;
      w         = '0;
      w.busy    = 1'b1;
      w.cond    = COND_NONE;
      w.jump_on = 1'b1;
      w.target  = STEP_IDLE;
      w.status  = STATUS_GRANTED;
      unique case (step)
         STEP_CLEAR: begin
            w.wr_clear = 1'b1;
            w.idx_inc  = 1'b1;
            w.cond     = COND_SEG_END;
            w.jump_on  = 1'b0;
            w.target   = STEP_CLEAR;
         end
         STEP_IDLE: begin
            w.busy    = 1'b0;
            w.idx_clr = 1'b1;
            w.cond    = COND_GO;
            w.jump_on = 1'b0;
            w.target  = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            w.idx_clr = 1'b1;
            w.cond    = COND_OVERFLOW;
            w.target  = STEP_TOO_LONG;
         end
         STEP_CHK_START: begin
            w.cond   = COND_N_ZERO;
            w.target = STEP_REL_START;
         end
         STEP_CHK_RD: begin
            w.rd_stage = 1'b1;
         end
         STEP_CHK_OWN: begin
            w.rd_owner = 1'b1;
         end
         STEP_CHK_CMP: begin
            w.idx_inc = 1'b1;
            w.cond    = COND_CHK_MORE;
            w.target  = STEP_CHK_RD;
         end
         STEP_CHK_END: begin
            w.cond   = COND_CONFLICT;
            w.target = STEP_CONFLICT;
         end
         STEP_REL_START: begin
            w.idx_clr = 1'b1;
            w.cond    = COND_H_ZERO;
            w.target  = STEP_CLM_START;
         end
         STEP_REL_RD: begin
            w.rd_held = 1'b1;
         end
         STEP_REL_WR: begin
            w.wr_free = 1'b1;
            w.idx_inc = 1'b1;
            w.cond    = COND_IDX_END_H;
            w.jump_on = 1'b0;
            w.target  = STEP_REL_RD;
         end
         STEP_CLM_START: begin
            w.idx_clr = 1'b1;
            w.cond    = COND_N_ZERO;
            w.target  = STEP_GRANT;
         end
         STEP_CLM_RD: begin
            w.rd_stage = 1'b1;
         end
         STEP_CLM_WR: begin
            w.wr_claim = 1'b1;
            w.idx_inc  = 1'b1;
            w.cond     = COND_IDX_END_N;
            w.jump_on  = 1'b0;
            w.target   = STEP_CLM_RD;
         end
         STEP_GRANT: begin
            w.set_len = 1'b1;
            w.respond = 1'b1;
            w.status  = STATUS_GRANTED;
            w.jump_on = 1'b0;
         end
         STEP_CONFLICT: begin
            w.respond = 1'b1;
            w.status  = STATUS_CONFLICT;
            w.jump_on = 1'b0;
         end
         STEP_TOO_LONG: begin
            w.respond = 1'b1;
            w.status  = STATUS_TOO_LONG;
            w.jump_on = 1'b0;
         end
         default: begin
            w.jump_on = 1'b0;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/track_segment_reservation_unit.sv
// Top level of the track segment reservation unit.
//
// Requests arrive on req_data and are taken at a clock edge where start is high and busy
// is low. Each request may add one segment to a shared stage; the request with last set
// decides the staged path for its train. A request without last leaves busy low, so such
// requests can follow each other on every cycle.
// A deciding request runs a short control program: it checks the owner of each staged
// segment, frees each segment that the train held before, then claims each staged
// segment, and busy stays high throughout. An empty request only frees the held path and
// is granted, an overlong one is refused as too long before any table work, and a
// conflict ends the check at the first staged segment that another train owns.
// The decision appears on rsp_data for exactly one cycle with rsp_valid high, in the
// first cycle that busy is low again; the receiver cannot stall it.
// After reset the owner table is cleared to free, one entry per cycle, which keeps busy
// high until the whole table is clear, so no request is taken before then.
module track_segment_reservation_unit #(
   parameter int SEGMENTS = tsr_pkg::SEGMENTS_DEF,
   parameter int MAX_PATH = tsr_pkg::MAX_PATH_DEF,
   parameter int TRAINS   = tsr_pkg::TRAINS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tsr_pkg::req_type req_data,
   output logic             rsp_valid,
   output tsr_pkg::rsp_type rsp_data
);
   import tsr_pkg::*;

   ucode_word_type ctl;
   flags_type      flags;

   // Program sequencer.
   tsr_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // Tables and datapath.
   tsr_datapath #(
      .SEGMENTS (SEGMENTS),
      .MAX_PATH (MAX_PATH),
      .TRAINS   (TRAINS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .ctl       (ctl),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign busy = ctl.busy;

endmodule

// File: rtl/tsr_sequencer.sv
// Step counter and conditional branch logic that runs the control program.
module tsr_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  tsr_pkg::flags_type      flags,
   output tsr_pkg::ucode_word_type ctl
);
   import tsr_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     cond_val;

   // Fetch the control word of the current step.
   assign ctl = ucode_fetch(step_ff);

   // Select the condition that the word tests.
   always_comb begin
      unique case (ctl.cond)
         COND_NONE:      cond_val = 1'b0;
         COND_GO:        cond_val = flags.go;
         COND_OVERFLOW:  cond_val = flags.overflow;
         COND_N_ZERO:    cond_val = flags.n_zero;
         COND_H_ZERO:    cond_val = flags.h_zero;
         COND_CHK_MORE:  cond_val = !flags.conflict && !flags.idx_end_n;
         COND_CONFLICT:  cond_val = flags.conflict;
         COND_IDX_END_N: cond_val = flags.idx_end_n;
         COND_IDX_END_H: cond_val = flags.idx_end_h;
         COND_SEG_END:   cond_val = flags.seg_end;
         default:        cond_val = 1'b0;
      endcase
   end

   // Branch or fall through.
   always_comb begin
      if (cond_val == ctl.jump_on) begin
         step_in = ctl.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // Reset starts the program at the owner table clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: rtl/tsr_datapath.sv
// Staging buffer, owner table, held path store and response register.
module tsr_datapath #(
   parameter int SEGMENTS = tsr_pkg::SEGMENTS_DEF,
   parameter int MAX_PATH = tsr_pkg::MAX_PATH_DEF,
   parameter int TRAINS   = tsr_pkg::TRAINS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  tsr_pkg::req_type        req_data,
   input  tsr_pkg::ucode_word_type ctl,
   output tsr_pkg::flags_type      flags,
   output logic                    rsp_valid,
   output tsr_pkg::rsp_type        rsp_data
);
   import tsr_pkg::*;

   localparam int SEG_W   = $clog2(SEGMENTS);
   localparam int TRAIN_W = (TRAINS > 1) ? $clog2(TRAINS) : 1;
   localparam int OWN_W   = $clog2(TRAINS + 1);
   localparam int LEN_W   = $clog2(MAX_PATH + 1);
   localparam int STG_AW  = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;
   localparam int IDX_W   = (SEG_W > LEN_W) ? SEG_W : LEN_W;
   localparam logic [OWN_W-1:0] FREE_OWNER = OWN_W'(TRAINS);

   // Reduce a segment index modulo SEGMENTS by restoring subtraction of shifted
   // multiples, one bit of quotient per step.
   function automatic logic [SEG_W-1:0] seg_reduce(input logic [SEG_IN_W-1:0] s);
      logic [SEG_IN_W-1:0] v;
      v = s;
      for (int k = SEG_IN_W - 1; k >= 0; k--) begin
         if (32'(v) >= (SEGMENTS << k)) begin
            v = v - SEG_IN_W'(SEGMENTS << k);
         end
      end
      return SEG_W'(v);
   endfunction

   // Reduce a train number modulo TRAINS in the same way.
   function automatic logic [TRAIN_W-1:0] train_reduce(input logic [TRAIN_IN_W-1:0] s);
      logic [TRAIN_IN_W-1:0] v;
      v = s;
      for (int k = TRAIN_IN_W - 1; k >= 0; k--) begin
         if (32'(v) >= (TRAINS << k)) begin
            v = v - TRAIN_IN_W'(TRAINS << k);
         end
      end
      return TRAIN_W'(v);
   endfunction

   logic                    accept;
   logic                    stage_full;
   logic                    stage_we;
   logic [SEG_W-1:0]        req_seg;

   logic [LEN_W-1:0]        staged_len_ff;
   logic                    overflow_ff;
   logic [TRAIN_W-1:0]      train_ff;
   logic [TRAIN_IN_W-1:0]   train_raw_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [SEG_W-1:0]        stage_q_ff;
   logic [SEG_W-1:0]        held_q_ff;
   logic [OWN_W-1:0]        owner_q_ff;
   logic [LEN_W-1:0]        held_len_ff [TRAINS];
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   logic [SEG_W-1:0]        stage_mem [MAX_PATH];
   logic [SEG_W-1:0]        held_mem  [TRAINS][MAX_PATH];
   logic [OWN_W-1:0]        owner_mem [SEGMENTS];

   logic                    own_we;
   logic [SEG_W-1:0]        own_waddr;
   logic [OWN_W-1:0]        own_wdata;
   logic [LEN_W-1:0]        held_len;
   logic [IDX_W:0]          idx_next;

   assign accept     = start && !ctl.busy;
   assign req_seg    = seg_reduce(req_data.segment);
   assign stage_full = (staged_len_ff == LEN_W'(MAX_PATH));
   assign stage_we   = accept && req_data.segment_valid && !stage_full;

   // Stage length and overflow flag; emptied when a decision is reported.
   always_ff @(posedge clock) begin
      if (reset) begin
         staged_len_ff <= '0;
         overflow_ff   <= 1'b0;
      end else if (ctl.respond) begin
         staged_len_ff <= '0;
         overflow_ff   <= 1'b0;
      end else if (accept && req_data.segment_valid) begin
         if (stage_full) begin
            overflow_ff <= 1'b1;
         end else begin
            staged_len_ff <= staged_len_ff + LEN_W'(1);
         end
      end
   end

   // Staged segment memory.
   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_mem[staged_len_ff[STG_AW-1:0]] <= req_seg;
      end
      if (ctl.rd_stage) begin
         stage_q_ff <= stage_mem[idx_ff[STG_AW-1:0]];
      end
   end

   // The deciding request's train, reduced for table work and raw for the response.
   always_ff @(posedge clock) begin
      if (accept && req_data.last) begin
         train_ff     <= train_reduce(req_data.train);
         train_raw_ff <= req_data.train;
      end
   end

   // Loop index shared by all program loops.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (ctl.idx_clr) begin
         idx_ff <= '0;
      end else if (ctl.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // Held path memory, one row per train.
   always_ff @(posedge clock) begin
      if (ctl.wr_claim) begin
         held_mem[train_ff][idx_ff[STG_AW-1:0]] <= stage_q_ff;
      end
      if (ctl.rd_held) begin
         held_q_ff <= held_mem[train_ff][idx_ff[STG_AW-1:0]];
      end
   end

   // Owner table write port: clearing pass, release or claim.
   always_comb begin
      own_we    = ctl.wr_clear || ctl.wr_free || ctl.wr_claim;
      own_waddr = stage_q_ff;
      own_wdata = OWN_W'(train_ff);
      if (ctl.wr_clear) begin
         own_waddr = idx_ff[SEG_W-1:0];
         own_wdata = FREE_OWNER;
      end else if (ctl.wr_free) begin
         own_waddr = held_q_ff;
         own_wdata = FREE_OWNER;
      end
   end

   // Owner table memory.
   always_ff @(posedge clock) begin
      if (own_we) begin
         owner_mem[own_waddr] <= own_wdata;
      end
      if (ctl.rd_owner) begin
         owner_q_ff <= owner_mem[stage_q_ff];
      end
   end

   // Held path lengths per train.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TRAINS; i++) begin
            held_len_ff[i] <= '0;
         end
      end else if (ctl.set_len) begin
         held_len_ff[train_ff] <= staged_len_ff;
      end
   end

   assign held_len = held_len_ff[train_ff];
   assign idx_next = {1'b0, idx_ff} + (IDX_W + 1)'(1);

   // Flags for the sequencer's jumps.
   always_comb begin
      flags.go        = accept && req_data.last;
      flags.overflow  = overflow_ff;
      flags.n_zero    = (staged_len_ff == '0);
      flags.h_zero    = (held_len == '0);
      flags.conflict  = !((owner_q_ff == FREE_OWNER) || (owner_q_ff == OWN_W'(train_ff)));
      flags.idx_end_n = (idx_next == (IDX_W + 1)'(staged_len_ff));
      flags.idx_end_h = (idx_next == (IDX_W + 1)'(held_len));
      flags.seg_end   = (idx_ff == IDX_W'(SEGMENTS - 1));
   end

   // Response register: one strobe cycle per decision.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.respond) begin
         rsp_data_ff.status    <= ctl.status;
         rsp_data_ff.train_out <= train_raw_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
